// ===== src/triangle_plane_from_vertex_store_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle plane block
// Concurrent checks that are sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_FROM_VERTEX_STORE_TOP_MACROS_SVH
`define TRIANGLE_PLANE_FROM_VERTEX_STORE_TOP_MACROS_SVH

// Check in the same cycle.
`define TPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check in the following cycle.
`define TPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tpv_pkg.sv =====
// ----------------------------------------------------------------------------
// tpv_pkg
// Widths, types and mode codes that the triangle plane block shares.
// ----------------------------------------------------------------------------
package tpv_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int ADDR_BITS    = $clog2(VERTEX_COUNT);
  localparam int COORD_BITS   = 24;            // stored bits of a coordinate
  localparam int COORD_W      = 24;            // field width of a coordinate
  localparam int IDX_W        = 10;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int NORM_W       = 51;
  localparam int MUL_W        = 51;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int MUL_CNT_W    = $clog2(MUL_W + 1);
  localparam int SQ_W         = 100;
  localparam int UNIT_W       = 31;            // magnitude bits of a unit component
  localparam int DOT_W        = 57;
  localparam int DIST_W       = 33;
  localparam int FRAC_BITS    = 60;
  localparam int ROOT_CNT_W   = $clog2(FRAC_BITS + 1);
  localparam int DIST_SHIFT   = 22;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RAW   = 2'd1,
    MODE_UNIT  = 2'd2,
    MODE_PLANE = 2'd3
  } mode_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

endpackage

// ===== src/tpv_if.sv =====
// ----------------------------------------------------------------------------
// tpv_in_if / tpv_out_if
// Valid/ready channels that carry an input item and a result item.
// ----------------------------------------------------------------------------
interface tpv_in_if;
  import tpv_pkg::*;

  logic         valid;
  logic         ready;
  logic [1:0]   mode;
  idx_t         vertex_slot;
  coord_t       coord_x;
  coord_t       coord_y;
  coord_t       coord_z;
  idx_t         corner_a;
  idx_t         corner_b;
  idx_t         corner_c;

  modport source (output valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, mode, vertex_slot, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface tpv_out_if;
  import tpv_pkg::*;

  logic   valid;
  logic   ready;
  norm_t  normal_x;
  norm_t  normal_y;
  norm_t  normal_z;
  dist_t  plane_distance;
  logic   valid_res;

  modport source (output valid, normal_x, normal_y, normal_z, plane_distance,
                  valid_res, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, plane_distance,
                  valid_res, output ready);
endinterface

// ===== src/tpv_mul.sv =====
// ----------------------------------------------------------------------------
// tpv_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tpv_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpv_pkg::MUL_W-1:0]  op_a,
  input  logic [tpv_pkg::MUL_W-1:0]  op_b,
  output logic                       busy,
  output logic                       done,
  output logic [tpv_pkg::PROD_W-1:0] product
);
  import tpv_pkg::*;

  logic [PROD_W-1:0]    mcand_r;
  logic [PROD_W-1:0]    acc_r;
  logic [MUL_W-1:0]     mplier_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == MUL_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MUL_CNT_W'(1);
        if (cnt_r == MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= PROD_W'(op_a);
      mplier_r <= op_b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== src/tpv_root.sv =====
// ----------------------------------------------------------------------------
// tpv_root
// Unit magnitude: floor(sqrt(floor(num * 2^60 / den))), one bit of the
// quotient and then one root bit per cycle.
// ----------------------------------------------------------------------------
module tpv_root (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpv_pkg::SQ_W-1:0]   num,
  input  logic [tpv_pkg::PROD_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [tpv_pkg::UNIT_W-1:0] root
);
  import tpv_pkg::*;

  localparam int REM_W  = PROD_W + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int RAD_W  = 2 * UNIT_W;
  localparam int SREM_W = UNIT_W + 4;

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

  rstate_t               state_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  done_r;
  logic [REM_W-1:0]      rem_r;
  logic [PROD_W-1:0]     den_r;
  logic [QUO_W-1:0]      quo_r;
  logic [RAD_W-1:0]      rad_r;
  logic [SREM_W-1:0]     srem_r;
  logic [UNIT_W-1:0]     root_r;

  logic [REM_W-1:0]      rem_cur;
  logic                  rem_ge;
  logic [REM_W-1:0]      rem_nxt;
  logic [QUO_W-1:0]      quo_nxt;
  logic [SREM_W-1:0]     srem_cur;
  logic [SREM_W-1:0]     trial;
  logic                  srem_ge;

  // long division: the integer part comes first, then one fraction bit a step
  always_comb begin
    rem_cur = (cnt_r == ROOT_CNT_W'(FRAC_BITS)) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    rem_ge  = rem_cur >= {1'b0, den_r};
    rem_nxt = rem_ge ? rem_cur - {1'b0, den_r} : rem_cur;
    quo_nxt = {quo_r[QUO_W-2:0], rem_ge};
  end

  // restoring square root, two radicand bits a step
  always_comb begin
    srem_cur = {srem_r[SREM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    srem_ge  = srem_cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        R_IDLE: begin
          if (start) begin
            rem_r   <= REM_W'(num);
            den_r   <= den;
            quo_r   <= '0;
            cnt_r   <= ROOT_CNT_W'(FRAC_BITS);
            state_r <= R_DIV;
          end
        end
        R_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == '0) begin
            rad_r   <= RAD_W'(quo_nxt);
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= ROOT_CNT_W'(UNIT_W - 1);
            state_r <= R_SQRT;
          end else begin
            cnt_r <= cnt_r - ROOT_CNT_W'(1);
          end
        end
        R_SQRT: begin
          rad_r  <= rad_r << 2;
          srem_r <= srem_ge ? srem_cur - trial : srem_cur;
          root_r <= {root_r[UNIT_W-2:0], srem_ge};
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= R_IDLE;
          end else begin
            cnt_r <= cnt_r - ROOT_CNT_W'(1);
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign busy = (state_r != R_IDLE);
  assign done = done_r;
  assign root = root_r;

endmodule

// ===== src/triangle_plane_from_vertex_store_top.sv =====
// Flow: a vertex write is stored at the edge that accepts it; a triangle result
//   is loaded into the output register at FIN, after CHK (raw or degenerate),
//   ROOT (unit normal) or DOT (plane). One item at a time; every multiply uses
//   the shared bit-serial multiplier and each unit component the root unit.
// Reset: synchronous active-low rst_n clears control; vertex store undefined.
// ----------------------------------------------------------------------------
// triangle_plane_from_vertex_store_top
// Vertex store with a bit-serial datapath that forms a triangle's normal,
// unit normal and plane distance.
// ----------------------------------------------------------------------------
`include "triangle_plane_from_vertex_store_top_macros.svh"

module triangle_plane_from_vertex_store_top (
  input  logic       clk,
  input  logic       rst_n,
  tpv_in_if.sink     in_ch,
  tpv_out_if.source  out_ch
);
  import tpv_pkg::*;

  // Sequence of one triangle item:
  //   LDA/LDC/LDB read the three corners (one store port, registered data),
  //   CROSS runs six signed products into the normal,
  //   CHK decides degenerate / raw result,
  //   SQ squares each component into the sum of squares,
  //   ROOT forms each unit component,
  //   DOT runs three products into the plane distance,
  //   FIN hands the item to the output register.
  typedef enum logic [3:0] {
    S_IDLE, S_LDA, S_LDC, S_LDB, S_CROSS, S_CHK, S_SQ, S_ROOT, S_DOT, S_FIN
  } state_t;

  state_t state_r;
  mode_t  mode_r;
  idx_t   cb_r;
  idx_t   cc_r;
  logic [2:0] step_r;
  logic   issue_r;
  logic   degen_r;

  coord_t v0x_r, v0y_r, v0z_r;
  logic signed [EDGE_W-1:0] e0x_r, e0y_r, e0z_r, e1x_r, e1y_r, e1z_r;
  norm_t  nx_r, ny_r, nz_r;
  logic [PROD_W-1:0] s_r;
  logic [SQ_W-1:0]   sq0_r, sq1_r, sq2_r;
  logic signed [UNIT_W:0] u0_r, u1_r, u2_r;
  logic signed [DOT_W-1:0] dot_r;

  // output register
  logic   out_valid_r;
  norm_t  out_nx_r, out_ny_r, out_nz_r;
  dist_t  out_dist_r;
  logic   out_vres_r;

  // vertex store
  logic [3*COORD_BITS-1:0] vstore_mem [VERTEX_COUNT];
  logic [3*COORD_BITS-1:0] rd_q_r;
  logic                    oor_r;
  idx_t                    rd_addr;
  coord_t                  rd_x, rd_y, rd_z;

  logic in_acc;
  logic wr_en;

  // multiplier and root unit
  logic              mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]  mop_a, mop_b;
  logic [PROD_W-1:0] mul_prod;
  logic              root_start, root_busy, root_done;
  logic [SQ_W-1:0]   root_num;
  logic [UNIT_W-1:0] root_q;

  // operand selection
  logic signed [EDGE_W-1:0] ca, cb;
  logic                     csub, cneg;
  logic [EDGE_W-1:0]        ca_mag, cb_mag;
  norm_t                    nsel;
  logic [NORM_W-1:0]        nmag;
  logic signed [UNIT_W:0]   usel;
  coord_t                   vsel;
  logic [UNIT_W:0]          umag;
  logic [COORD_W-1:0]       vmag;
  logic                     dneg;
  logic [NORM_W-1:0]        cterm;
  logic [DOT_W-1:0]         dterm;
  logic signed [UNIT_W:0]   uterm;

  // result assembly
  logic [DOT_W-1:0]  dot_abs;
  logic [DIST_W-1:0] dmag;
  dist_t             dist_val;
  logic              fin_load;
  logic              n_zero;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign wr_en  = in_acc && (mode_t'(in_ch.mode) == MODE_WRITE)
                  && (32'(in_ch.vertex_slot) < VERTEX_COUNT);

  // read address follows the corner sequence; the base corner goes in at acceptance
  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = in_ch.corner_a;
      S_LDA:   rd_addr = cc_r;
      default: rd_addr = cb_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vstore_mem[ADDR_BITS'(in_ch.vertex_slot)] <= {in_ch.coord_x[COORD_BITS-1:0],
                                                    in_ch.coord_y[COORD_BITS-1:0],
                                                    in_ch.coord_z[COORD_BITS-1:0]};
    end
    rd_q_r <= vstore_mem[ADDR_BITS'(rd_addr)];
    oor_r  <= 32'(rd_addr) >= VERTEX_COUNT;
  end

  // an index past the store reads as the origin
  assign rd_x = oor_r ? '0 : coord_t'(signed'(rd_q_r[3*COORD_BITS-1 -: COORD_BITS]));
  assign rd_y = oor_r ? '0 : coord_t'(signed'(rd_q_r[2*COORD_BITS-1 -: COORD_BITS]));
  assign rd_z = oor_r ? '0 : coord_t'(signed'(rd_q_r[COORD_BITS-1:0]));

  // cross product terms
  always_comb begin
    ca   = e0y_r;
    cb   = e1z_r;
    csub = 1'b0;
    unique case (step_r)
      3'd0:    begin ca = e0y_r; cb = e1z_r; csub = 1'b0; end
      3'd1:    begin ca = e0z_r; cb = e1y_r; csub = 1'b1; end
      3'd2:    begin ca = e0z_r; cb = e1x_r; csub = 1'b0; end
      3'd3:    begin ca = e0x_r; cb = e1z_r; csub = 1'b1; end
      3'd4:    begin ca = e0x_r; cb = e1y_r; csub = 1'b0; end
      default: begin ca = e0y_r; cb = e1x_r; csub = 1'b1; end
    endcase
    ca_mag = ca[EDGE_W-1] ? EDGE_W'(-ca) : EDGE_W'(ca);
    cb_mag = cb[EDGE_W-1] ? EDGE_W'(-cb) : EDGE_W'(cb);
    cneg   = ca[EDGE_W-1] ^ cb[EDGE_W-1] ^ csub;
  end

  // per-component selections for squares, roots and the dot product
  always_comb begin
    unique case (step_r)
      3'd0: begin
        nsel = nx_r; usel = u0_r; vsel = v0x_r; root_num = sq0_r;
      end
      3'd1: begin
        nsel = ny_r; usel = u1_r; vsel = v0y_r; root_num = sq1_r;
      end
      default: begin
        nsel = nz_r; usel = u2_r; vsel = v0z_r; root_num = sq2_r;
      end
    endcase
    nmag = nsel[NORM_W-1] ? NORM_W'(-nsel) : NORM_W'(nsel);
    umag = usel[UNIT_W] ? (UNIT_W + 1)'(-usel) : (UNIT_W + 1)'(usel);
    vmag = vsel[COORD_W-1] ? COORD_W'(-vsel) : COORD_W'(vsel);
    dneg = usel[UNIT_W] ^ vsel[COORD_W-1];
  end

  always_comb begin
    unique case (state_r)
      S_CROSS: begin mop_a = MUL_W'(ca_mag); mop_b = MUL_W'(cb_mag); end
      S_SQ:    begin mop_a = MUL_W'(nmag);   mop_b = MUL_W'(nmag);   end
      S_DOT:   begin mop_a = MUL_W'(umag);   mop_b = MUL_W'(vmag);   end
      default: begin mop_a = '0;             mop_b = '0;             end
    endcase
  end

  assign mul_start  = issue_r && ((state_r == S_CROSS) || (state_r == S_SQ)
                                  || (state_r == S_DOT));
  assign root_start = issue_r && (state_r == S_ROOT);

  // signed terms from the unsigned product
  assign cterm = cneg ? -NORM_W'(mul_prod) : NORM_W'(mul_prod);
  assign dterm = dneg ? -DOT_W'(mul_prod) : DOT_W'(mul_prod);
  assign uterm = nsel[NORM_W-1] ? -$signed({1'b0, root_q}) : $signed({1'b0, root_q});

  assign n_zero = (nx_r == '0) && (ny_r == '0) && (nz_r == '0);

  // plane distance: magnitude of the dot product, truncated toward zero
  assign dot_abs  = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign dmag     = DIST_W'(dot_abs >> DIST_SHIFT);
  assign dist_val = dot_r[DOT_W-1] ? -dist_t'(dmag) : dist_t'(dmag);

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      issue_r     <= 1'b0;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, hold it otherwise
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (mul_start || root_start) begin
        issue_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (mode_t'(in_ch.mode) != MODE_WRITE)) begin
            mode_r  <= mode_t'(in_ch.mode);
            cb_r    <= in_ch.corner_b;
            cc_r    <= in_ch.corner_c;
            degen_r <= 1'b0;
            state_r <= S_LDA;
          end
        end
        S_LDA: begin
          v0x_r   <= rd_x;
          v0y_r   <= rd_y;
          v0z_r   <= rd_z;
          state_r <= S_LDC;
        end
        S_LDC: begin
          e0x_r   <= EDGE_W'(rd_x) - EDGE_W'(v0x_r);
          e0y_r   <= EDGE_W'(rd_y) - EDGE_W'(v0y_r);
          e0z_r   <= EDGE_W'(rd_z) - EDGE_W'(v0z_r);
          state_r <= S_LDB;
        end
        S_LDB: begin
          e1x_r   <= EDGE_W'(rd_x) - EDGE_W'(v0x_r);
          e1y_r   <= EDGE_W'(rd_y) - EDGE_W'(v0y_r);
          e1z_r   <= EDGE_W'(rd_z) - EDGE_W'(v0z_r);
          step_r  <= '0;
          issue_r <= 1'b1;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          if (mul_done) begin
            unique case (step_r)
              3'd0:    nx_r <= norm_t'(cterm);
              3'd1:    nx_r <= nx_r + norm_t'(cterm);
              3'd2:    ny_r <= norm_t'(cterm);
              3'd3:    ny_r <= ny_r + norm_t'(cterm);
              3'd4:    nz_r <= norm_t'(cterm);
              default: nz_r <= nz_r + norm_t'(cterm);
            endcase
            if (step_r == 3'd5) begin
              state_r <= S_CHK;
            end else begin
              step_r  <= step_r + 3'd1;
              issue_r <= 1'b1;
            end
          end
        end
        S_CHK: begin
          step_r <= '0;
          if (mode_r == MODE_RAW) begin
            state_r <= S_FIN;
          end else if (n_zero) begin
            degen_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            issue_r <= 1'b1;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            s_r <= (step_r == 3'd0) ? mul_prod : s_r + mul_prod;
            unique case (step_r)
              3'd0:    sq0_r <= SQ_W'(mul_prod);
              3'd1:    sq1_r <= SQ_W'(mul_prod);
              default: sq2_r <= SQ_W'(mul_prod);
            endcase
            issue_r <= 1'b1;
            if (step_r == 3'd2) begin
              step_r  <= '0;
              state_r <= S_ROOT;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_ROOT: begin
          if (root_done) begin
            unique case (step_r)
              3'd0:    u0_r <= uterm;
              3'd1:    u1_r <= uterm;
              default: u2_r <= uterm;
            endcase
            if (step_r == 3'd2) begin
              step_r <= '0;
              if (mode_r == MODE_PLANE) begin
                issue_r <= 1'b1;
                state_r <= S_DOT;
              end else begin
                state_r <= S_FIN;
              end
            end else begin
              step_r  <= step_r + 3'd1;
              issue_r <= 1'b1;
            end
          end
        end
        S_DOT: begin
          if (mul_done) begin
            dot_r <= (step_r == 3'd0) ? $signed(dterm) : dot_r + $signed(dterm);
            if (step_r == 3'd2) begin
              state_r <= S_FIN;
            end else begin
              step_r  <= step_r + 3'd1;
              issue_r <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (fin_load) begin
            if (mode_r == MODE_RAW) begin
              out_nx_r   <= nx_r;
              out_ny_r   <= ny_r;
              out_nz_r   <= nz_r;
              out_dist_r <= '0;
              out_vres_r <= 1'b1;
            end else if (degen_r) begin
              out_nx_r   <= '0;
              out_ny_r   <= '0;
              out_nz_r   <= '0;
              out_dist_r <= '0;
              out_vres_r <= 1'b0;
            end else begin
              out_nx_r   <= norm_t'(u0_r);
              out_ny_r   <= norm_t'(u1_r);
              out_nz_r   <= norm_t'(u2_r);
              out_dist_r <= (mode_r == MODE_PLANE) ? dist_val : '0;
              out_vres_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  tpv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mop_a),
    .op_b    (mop_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  tpv_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .num   (root_num),
    .den   (s_r),
    .busy  (root_busy),
    .done  (root_done),
    .root  (root_q)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.normal_x       = out_nx_r;
  assign out_ch.normal_y       = out_ny_r;
  assign out_ch.normal_z       = out_nz_r;
  assign out_ch.plane_distance = out_dist_r;
  assign out_ch.valid_res      = out_vres_r;

  `TPV_ASSERT_NOW(a_mul_free, mul_start, !mul_busy, "multiplier started while busy")
  `TPV_ASSERT_NOW(a_root_free, root_start, !root_busy, "root unit started while busy")
  `TPV_ASSERT_NOW(a_degen_zero, out_ch.valid && !out_ch.valid_res,
    (out_ch.normal_x == '0) && (out_ch.normal_y == '0) && (out_ch.normal_z == '0)
    && (out_ch.plane_distance == '0), "degenerate item with non-zero fields")
  `TPV_ASSERT_NEXT(a_tri_busy, in_acc && (in_ch.mode != MODE_WRITE), !in_ch.ready,
    "triangle item accepted but block still ready")

endmodule

// ===== sim/triangle_plane_checker.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_checker
// Watches both channels of the triangle plane block, keeps its own copy of
// the vertex store, works out the expected normal and plane of each triangle
// item and compares every result item against the oldest expectation.
// ----------------------------------------------------------------------------
module triangle_plane_checker (
  input  logic  clk,
  input  logic  rst_n,
  tpv_in_if     in_ch,
  tpv_out_if    out_ch,
  output int    fail_count,
  output int    pending
);
  import tpv_pkg::*;

  typedef struct packed {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    dist_t plane_dist;
    logic  usable;
  } plane_t;

  // two-state arrays start at zero
  longint vx [VERTEX_COUNT];
  longint vy [VERTEX_COUNT];
  longint vz [VERTEX_COUNT];
  plane_t plane_q[$];

  // Largest q in [0, 2^30] with q^2 * s <= m^2 * 2^60.
  function automatic longint unit_length(longint unsigned m, logic [191:0] s);
    logic [191:0] target;
    logic [191:0] prod;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    target = ({128'b0, m} * {128'b0, m}) << 60;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid  = lo + (hi - lo + 1) / 2;
      prod = {128'b0, mid * mid} * s;
      if (prod <= target) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic plane_t triangle_plane(mode_t md, idx_t ca, idx_t cb, idx_t cc);
    plane_t r;
    longint p0 [3];
    longint p1 [3];
    longint p2 [3];
    longint e0 [3];
    longint e1 [3];
    longint n  [3];
    longint u  [3];
    longint unsigned mg;
    logic [191:0] s;
    longint dot;
    longint d;
    p0 = '{vx[ca], vy[ca], vz[ca]};
    p1 = '{vx[cc], vy[cc], vz[cc]};
    p2 = '{vx[cb], vy[cb], vz[cb]};
    for (int i = 0; i < 3; i++) begin
      e0[i] = p1[i] - p0[i];
      e1[i] = p2[i] - p0[i];
    end
    n[0] = e0[1] * e1[2] - e0[2] * e1[1];
    n[1] = e0[2] * e1[0] - e0[0] * e1[2];
    n[2] = e0[0] * e1[1] - e0[1] * e1[0];
    r = '0;
    r.usable = 1'b1;
    if (md == MODE_RAW) begin
      r.nx = n[0][NORM_W-1:0];
      r.ny = n[1][NORM_W-1:0];
      r.nz = n[2][NORM_W-1:0];
      return r;
    end
    // a collapsed triangle has no direction: all zeros, flagged unusable
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.usable = 1'b0;
      return r;
    end
    s = '0;
    for (int i = 0; i < 3; i++) begin
      mg = (n[i] < 0) ? -n[i] : n[i];
      s  = s + {128'b0, mg} * {128'b0, mg};
    end
    for (int i = 0; i < 3; i++) begin
      mg   = (n[i] < 0) ? -n[i] : n[i];
      u[i] = unit_length(mg, s);
      if (n[i] < 0) u[i] = -u[i];
    end
    r.nx = u[0][NORM_W-1:0];
    r.ny = u[1][NORM_W-1:0];
    r.nz = u[2][NORM_W-1:0];
    if (md == MODE_PLANE) begin
      dot = u[0] * p0[0] + u[1] * p0[1] + u[2] * p0[2];
      d   = ((dot < 0) ? -dot : dot) >>> DIST_SHIFT;
      if (dot < 0) d = -d;
      r.plane_dist = d[DIST_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    plane_t got;
    plane_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (mode_t'(in_ch.mode) == MODE_WRITE) begin
        vx[in_ch.vertex_slot] = in_ch.coord_x;
        vy[in_ch.vertex_slot] = in_ch.coord_y;
        vz[in_ch.vertex_slot] = in_ch.coord_z;
      end else begin
        plane_q.push_back(triangle_plane(mode_t'(in_ch.mode), in_ch.corner_a,
                                         in_ch.corner_b, in_ch.corner_c));
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
              out_ch.plane_distance, out_ch.valid_res};
      if (plane_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = plane_q.pop_front();
        if (got.nx !== want.nx) begin
          $error("normal_x expected %0d got %0d", want.nx, got.nx);
          fail_count++;
        end
        if (got.ny !== want.ny) begin
          $error("normal_y expected %0d got %0d", want.ny, got.ny);
          fail_count++;
        end
        if (got.nz !== want.nz) begin
          $error("normal_z expected %0d got %0d", want.nz, got.nz);
          fail_count++;
        end
        if (got.plane_dist !== want.plane_dist) begin
          $error("plane_distance expected %0d got %0d", want.plane_dist,
                 got.plane_dist);
          fail_count++;
        end
        if (got.usable !== want.usable) begin
          $error("valid_res expected %0b got %0b", want.usable, got.usable);
          fail_count++;
        end
      end
    end
    pending = plane_q.size();
  end

endmodule

// ===== sim/triangle_plane_from_vertex_store_top_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_from_vertex_store_top_tb
// Loads vertices into the block and asks for raw normals, unit normals and
// plane equations of triangles over them, directed first and random after,
// with bursty input and a stalling receiver; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module triangle_plane_from_vertex_store_top_tb;
  import tpv_pkg::*;

  localparam int RANDOM_ITEMS = 1830;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   written[$];       // slots holding a vertex; corners are drawn from here
  bit   is_written [VERTEX_COUNT];

  tpv_in_if  in_ch();
  tpv_out_if out_ch();

  triangle_plane_from_vertex_store_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  triangle_plane_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the time limit covers the slowest triangle for every item many times.
  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: alternate between always ready, light stalls and long stalls.
  int stall_phase = 0;
  int phase_left  = 0;
  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_phase <= $urandom_range(0, 2);
      phase_left  <= $urandom_range(50, 3000);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (stall_phase)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Hold valid until the block takes the item; the caller decides on gaps.
  task automatic send_item(mode_t md, idx_t slot, coord_t x, coord_t y, coord_t z,
                           idx_t ca, idx_t cb, idx_t cc);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= md;
    in_ch.vertex_slot <= slot;
    in_ch.coord_x     <= x;
    in_ch.coord_y     <= y;
    in_ch.coord_z     <= z;
    in_ch.corner_a    <= ca;
    in_ch.corner_b    <= cb;
    in_ch.corner_c    <= cc;
    do @(posedge clk); while (!in_ch.ready);
    if (md == MODE_WRITE && !is_written[slot]) begin
      is_written[slot] = 1'b1;
      written.push_back(slot);
    end
  endtask

  task automatic load_vertex(idx_t slot, coord_t x, coord_t y, coord_t z);
    send_item(MODE_WRITE, slot, x, y, z, idx_t'($urandom), idx_t'($urandom),
              idx_t'($urandom));
  endtask

  task automatic ask_triangle(mode_t md, idx_t ca, idx_t cb, idx_t cc);
    send_item(md, idx_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), ca, cb, cc);
  endtask

  // Mix full-range, small and extreme coordinates.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'(24'h7fffff);
      1:       return coord_t'(24'h800000);
      2, 3, 4: return coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic idx_t pick_corner();
    return idx_t'(written[$urandom_range(0, written.size() - 1)]);
  endfunction

  initial begin
    int burst_left;
    int wait_cycles;
    mode_t md;
    idx_t ca;
    idx_t cb;
    idx_t cc;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_WRITE;
    in_ch.vertex_slot <= '0;
    in_ch.coord_x   <= '0;
    in_ch.coord_y   <= '0;
    in_ch.coord_z   <= '0;
    in_ch.corner_a  <= '0;
    in_ch.corner_b  <= '0;
    in_ch.corner_c  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme vertices, axis-aligned unit triangle, every mode,
    // a collapsed triangle and a collinear one.
    load_vertex(10'd0,    coord_t'(24'h7fffff), coord_t'(24'h7fffff), coord_t'(24'h7fffff));
    load_vertex(10'd1023, coord_t'(24'h800000), coord_t'(24'h800000), coord_t'(24'h800000));
    load_vertex(10'd1,    coord_t'(0),   coord_t'(0),   coord_t'(0));
    load_vertex(10'd2,    coord_t'(256), coord_t'(0),   coord_t'(0));
    load_vertex(10'd3,    coord_t'(0),   coord_t'(256), coord_t'(0));
    load_vertex(10'd4,    coord_t'(0),   coord_t'(0),   coord_t'(256));
    load_vertex(10'd5,    coord_t'(24'h7fffff), coord_t'(24'h800000), coord_t'(5));
    load_vertex(10'd6,    coord_t'(512), coord_t'(0),   coord_t'(0));
    ask_triangle(MODE_RAW,   10'd1, 10'd3, 10'd2);
    ask_triangle(MODE_UNIT,  10'd1, 10'd3, 10'd2);
    ask_triangle(MODE_PLANE, 10'd2, 10'd4, 10'd3);
    ask_triangle(MODE_PLANE, 10'd4, 10'd2, 10'd3);
    ask_triangle(MODE_RAW,   10'd0, 10'd5, 10'd1023);
    ask_triangle(MODE_UNIT,  10'd0, 10'd5, 10'd1023);
    ask_triangle(MODE_PLANE, 10'd0, 10'd5, 10'd1023);
    ask_triangle(MODE_PLANE, 10'd1023, 10'd5, 10'd0);
    ask_triangle(MODE_RAW,   10'd2, 10'd2, 10'd2);
    ask_triangle(MODE_UNIT,  10'd2, 10'd2, 10'd2);
    ask_triangle(MODE_PLANE, 10'd1, 10'd6, 10'd2);
    ask_triangle(MODE_PLANE, 10'd0, 10'd1023, 10'd1);

    // Random: bursts of items with gaps between them.
    burst_left = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        wait_cycles = $urandom_range(1, 40);
        repeat (wait_cycles) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      if ($urandom_range(0, 99) < 35) begin
        load_vertex(idx_t'($urandom), pick_coord(), pick_coord(), pick_coord());
      end else begin
        md = mode_t'($urandom_range(1, 3));
        ca = pick_corner();
        cb = pick_corner();
        cc = pick_corner();
        // force a collapsed triangle now and then
        case ($urandom_range(0, 19))
          0:       cb = ca;
          1:       cc = ca;
          2:       cc = cb;
          default: ;
        endcase
        ask_triangle(md, ca, cb, cc);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: let the checker see the last acceptance, wait for every
    // expected result, then pause to catch any stray item.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
